// ----- rtl/brni_pkg.sv -----
// brni_pkg: shared types, codes and the squared-distance helper
// used by the roadmap node insertion block and its arithmetic units
// depends on nothing
package brni_pkg;

    localparam int PT_W   = 48;   // packed point {x, y, z}, 10.6 each
    localparam int DIST_W = 34;   // squared distance
    localparam int BUB_W  = 17;   // 11.6 radius
    localparam int PROD_W = 33;   // |axis diff| * bubble

    typedef logic [PT_W-1:0]   t_pt;
    typedef logic [DIST_W-1:0] t_dist;
    typedef logic [BUB_W-1:0]  t_bub;
    typedef logic [PROD_W-1:0] t_prod;

    localparam logic [1:0] OP_OBST   = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_START  = 2'd2;

    localparam logic [1:0] ST_OBST   = 2'd0;
    localparam logic [1:0] ST_START  = 2'd1;
    localparam logic [1:0] ST_EDGE   = 2'd2;
    localparam logic [1:0] ST_REJECT = 2'd3;

    function automatic logic [15:0] axis_gap(input logic [15:0] a, input logic [15:0] b);
        axis_gap = (a >= b) ? (a - b) : (b - a);
    endfunction

    function automatic t_dist sq_dist(input t_pt a, input t_pt b);
        logic [15:0] gx;
        logic [15:0] gy;
        logic [15:0] gz;
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] sz;
        gx = axis_gap(a[47:32], b[47:32]);
        gy = axis_gap(a[31:16], b[31:16]);
        gz = axis_gap(a[15:0],  b[15:0]);
        sx = 32'(gx) * 32'(gx);
        sy = 32'(gy) * 32'(gy);
        sz = 32'(gz) * 32'(gz);
        sq_dist = DIST_W'(sx) + DIST_W'(sy) + DIST_W'(sz);
    endfunction

endpackage

// ----- rtl/brni_sqrt.sv -----
// brni_sqrt: floor square root of a squared distance, two bits a cycle
// depends on brni_pkg
module brni_sqrt (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_go,
    input  brni_pkg::t_dist i_val,
    output logic           o_done,
    output brni_pkg::t_bub o_root
);
    import brni_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    t_dist       r_val;
    logic [19:0] r_rem;
    t_bub        r_root;
    logic [19:0] rem2;
    logic [19:0] trial;

    assign rem2  = {r_rem[17:0], r_val[DIST_W-1 -: 2]};
    assign trial = 20'({r_root, 2'b01});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(BUB_W);
                r_val  <= i_val;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_val <= r_val << 2;
                if (rem2 >= trial) begin
                    r_rem  <= rem2 - trial;
                    r_root <= {r_root[BUB_W-2:0], 1'b1};
                end else begin
                    r_rem  <= rem2;
                    r_root <= {r_root[BUB_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

// ----- rtl/brni_div.sv -----
// brni_div: restoring divider for the steering offset, one quotient bit a cycle
// depends on brni_pkg
module brni_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_go,
    input  brni_pkg::t_prod i_dividend,
    input  brni_pkg::t_bub  i_divisor,
    output logic            o_done,
    output brni_pkg::t_prod o_quot
);
    import brni_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    t_prod       r_q;
    t_bub        r_dvs;
    logic [17:0] r_rem;
    logic [17:0] rem2;

    assign rem2 = {r_rem[16:0], r_q[PROD_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(PROD_W);
                r_q    <= i_dividend;
                r_dvs  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                if (rem2 >= {1'b0, r_dvs}) begin
                    r_rem <= rem2 - {1'b0, r_dvs};
                    r_q   <= {r_q[PROD_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem2;
                    r_q   <= {r_q[PROD_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// ----- rtl/bubble_roadmap_node_insert_top.sv -----
// bubble_roadmap_node_insert_top: roadmap graph growth with free-space bubbles
// timing: obstacle store and rejects give their beat the cycle after start;
//   start placement scans the obstacles and takes one square root, none with no obstacles;
//   a sample scans nodes and obstacles twice each, takes up to three roots and may steer (mul, divide, apply)
// one item at a time, busy held high while a start or sample is worked; results cannot be stalled
// reset: synchronous active low, clears counts and control; memories are not cleared
// depends on brni_pkg, brni_sqrt, brni_div
module bubble_roadmap_node_insert_top #(
    parameter int NODES     = 64,
    parameter int OBSTACLES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_pos_x,
    input  logic [15:0] i_pos_y,
    input  logic [15:0] i_pos_z,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [5:0]  o_node_index,
    output logic [5:0]  o_neighbor_index,
    output logic [15:0] o_node_x,
    output logic [15:0] o_node_y,
    output logic [15:0] o_node_z,
    output logic [16:0] o_bubble,
    output logic        o_last
);
    import brni_pkg::*;

    localparam int NW  = $clog2(NODES);
    localparam int NCW = $clog2(NODES + 1);
    localparam int OAW = (OBSTACLES > 1) ? $clog2(OBSTACLES) : 1;
    localparam int OCW = $clog2(OBSTACLES + 1);
    localparam int SW  = (OAW > NW) ? OAW : NW;
    localparam int NE_W = PT_W + BUB_W;

    typedef enum logic [3:0] {
        S_IDLE, S_NEAR, S_SQD, S_BUB, S_SQB, S_DECIDE, S_MUL, S_DIV,
        S_APPLY, S_NBGO, S_LIM, S_LINK
    } t_state;
    typedef enum logic [1:0] {M_BUB, M_NEAR, M_LINK} t_mode;
    typedef enum logic [1:0] {PH_START, PH_OWN, PH_NEW} t_phase;

    // obstacle points and node entries {pos, bubble}
    t_pt             obs_mem  [OBSTACLES];
    logic [NE_W-1:0] node_mem [NODES];
    t_pt             obs_rd;
    logic [NE_W-1:0] node_rd;

    t_state r_state;
    t_mode  r_mode;
    t_phase r_phase;

    logic [OCW-1:0] r_ocount;
    logic [NCW-1:0] r_ncount;

    // write ports, registered behind the control
    logic            r_owe;
    logic [OAW-1:0]  r_owaddr;
    t_pt             r_owdata;
    logic            r_nwe;
    logic [NW-1:0]   r_nwaddr;
    logic [NE_W-1:0] r_nwdata;

    // scan pipeline: issue, read data, distance
    logic            r_scan_on;
    logic            r_src_node;
    logic [SW-1:0]   r_scan_addr;
    logic [SW-1:0]   r_scan_end;
    logic            r_v1;
    logic [SW-1:0]   r_idx1;
    logic            r_v2;
    logic [SW-1:0]   r_idx2;
    t_dist           r_dist2;
    logic [NE_W-1:0] r_nd2;
    logic            scan_idle;

    t_pt            r_p;
    t_pt            r_tgt;
    t_pt            r_q;
    t_pt            r_npos;
    t_bub           r_nbub;
    t_dist          r_best;
    t_bub           r_d;
    t_bub           r_own;
    t_bub           r_nb;
    logic [NW-1:0]  r_idx;
    logic [NW-1:0]  r_pend;
    logic [35:0]    r_lim2;
    logic [1:0]     r_k;
    logic           r_neg;
    t_prod          r_prod;

    logic  r_sq_go;
    t_dist r_sq_in;
    logic  sq_done;
    t_bub  sq_root;
    logic  r_div_go;
    logic  div_done;
    t_prod div_quot;

    // result beat registers
    logic          r_valid;
    logic [1:0]    r_status;
    logic [NW-1:0] r_o_node;
    logic [NW-1:0] r_o_nbr;
    t_pt           r_o_pos;
    t_bub          r_o_bub;
    logic          r_last;

    // combinational helpers
    t_pt         src_pt;
    t_bub        lim;
    t_bub        sq_val;
    logic [15:0] pk;
    logic [15:0] nk;
    logic [33:0] sum_k;
    logic [15:0] qk;
    logic [17:0] nb_inc;

    assign scan_idle = !r_scan_on && !r_v1 && !r_v2;
    assign src_pt    = r_src_node ? node_rd[NE_W-1:BUB_W] : obs_rd;
    assign lim       = (r_nbub > r_own) ? r_nbub : r_own;
    assign sq_val    = (r_ocount == '0) ? '0 : sq_root;
    assign pk        = r_p[(2 - r_k) * 16 +: 16];
    assign nk        = r_npos[(2 - r_k) * 16 +: 16];
    assign sum_k     = 34'(nk) + 34'(div_quot);
    assign nb_inc    = 18'(r_nb) + 18'd1;

    // steered axis: truncated offset, clamped to the coordinate range
    always_comb begin
        if (r_neg) begin
            qk = (div_quot > PROD_W'(nk)) ? 16'd0 : 16'(34'(nk) - 34'(div_quot));
        end else begin
            qk = (sum_k > 34'd65535) ? 16'hFFFF : sum_k[15:0];
        end
    end

    brni_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_sq_go),
        .i_val   (r_sq_in),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    brni_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (r_div_go),
        .i_dividend (r_prod),
        .i_divisor  (r_d),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (r_owe) begin
            obs_mem[r_owaddr] <= r_owdata;
        end
        obs_rd <= obs_mem[r_scan_addr[OAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r_nwe) begin
            node_mem[r_nwaddr] <= r_nwdata;
        end
        node_rd <= node_mem[r_scan_addr[NW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ocount  <= '0;
            r_ncount  <= '0;
            r_owe     <= 1'b0;
            r_nwe     <= 1'b0;
            r_scan_on <= 1'b0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_sq_go   <= 1'b0;
            r_div_go  <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_valid  <= 1'b0;
            r_sq_go  <= 1'b0;
            r_div_go <= 1'b0;
            r_owe    <= 1'b0;
            r_nwe    <= 1'b0;

            // scan issue and distance stage
            if (r_scan_on) begin
                r_scan_addr <= r_scan_addr + SW'(1);
                if (r_scan_addr == r_scan_end) begin
                    r_scan_on <= 1'b0;
                end
            end
            r_v1    <= r_scan_on;
            r_idx1  <= r_scan_addr;
            r_v2    <= r_v1;
            r_idx2  <= r_idx1;
            r_dist2 <= sq_dist(r_tgt, src_pt);
            r_nd2   <= node_rd;

            // compare stage
            if (r_v2) begin
                case (r_mode)
                    M_BUB: begin
                        if (r_idx2 == '0 || r_dist2 < r_best) begin
                            r_best <= r_dist2;
                        end
                    end
                    M_NEAR: begin
                        // strict compare keeps the lowest index on a tie
                        if (r_idx2 == '0 || r_dist2 < r_best) begin
                            r_best <= r_dist2;
                            r_npos <= r_nd2[NE_W-1:BUB_W];
                            r_nbub <= r_nd2[BUB_W-1:0];
                        end
                    end
                    M_LINK: begin
                        // isqrt(s) <= nb  is  s < (nb+1)^2
                        if (36'(r_dist2) < r_lim2) begin
                            r_valid  <= 1'b1;
                            r_status <= ST_EDGE;
                            r_o_node <= r_idx;
                            r_o_nbr  <= r_pend;
                            r_o_pos  <= r_q;
                            r_o_bub  <= r_nb;
                            r_last   <= 1'b0;
                            r_pend   <= r_idx2[NW-1:0];
                        end
                    end
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_p   <= {i_pos_x, i_pos_y, i_pos_z};
                        r_tgt <= {i_pos_x, i_pos_y, i_pos_z};
                        r_q   <= {i_pos_x, i_pos_y, i_pos_z};
                        // zero-field beat for obstacle and reject
                        r_o_node <= '0;
                        r_o_nbr  <= '0;
                        r_o_pos  <= '0;
                        r_o_bub  <= '0;
                        r_last   <= 1'b1;
                        case (i_opcode)
                            OP_OBST: begin
                                r_valid <= 1'b1;
                                if (r_ocount == OCW'(OBSTACLES)) begin
                                    r_status <= ST_REJECT;
                                end else begin
                                    r_status <= ST_OBST;
                                    r_owe    <= 1'b1;
                                    r_owaddr <= r_ocount[OAW-1:0];
                                    r_owdata <= {i_pos_x, i_pos_y, i_pos_z};
                                    r_ocount <= r_ocount + OCW'(1);
                                end
                            end
                            OP_START: begin
                                r_phase     <= PH_START;
                                r_mode      <= M_BUB;
                                r_src_node  <= 1'b0;
                                r_scan_on   <= (r_ocount != '0);
                                r_scan_addr <= '0;
                                r_scan_end  <= SW'(r_ocount - OCW'(1));
                                r_state     <= S_BUB;
                            end
                            OP_SAMPLE: begin
                                if (r_ncount == '0 || r_ncount == NCW'(NODES)) begin
                                    r_valid  <= 1'b1;
                                    r_status <= ST_REJECT;
                                end else begin
                                    r_idx       <= r_ncount[NW-1:0];
                                    r_mode      <= M_NEAR;
                                    r_src_node  <= 1'b1;
                                    r_scan_on   <= 1'b1;
                                    r_scan_addr <= '0;
                                    r_scan_end  <= SW'(r_ncount - NCW'(1));
                                    r_state     <= S_NEAR;
                                end
                            end
                            default: begin
                                r_valid  <= 1'b1;
                                r_status <= ST_REJECT;
                            end
                        endcase
                    end
                end
                S_NEAR: begin
                    if (scan_idle) begin
                        r_sq_go <= 1'b1;
                        r_sq_in <= r_best;
                        r_state <= S_SQD;
                    end
                end
                S_SQD: begin
                    if (sq_done) begin
                        r_d         <= sq_root;
                        r_phase     <= PH_OWN;
                        r_mode      <= M_BUB;
                        r_src_node  <= 1'b0;
                        r_scan_on   <= (r_ocount != '0);
                        r_scan_addr <= '0;
                        r_scan_end  <= SW'(r_ocount - OCW'(1));
                        r_state     <= S_BUB;
                    end
                end
                S_BUB: begin
                    if (scan_idle) begin
                        // no obstacles: bubble is zero, no root needed
                        if (r_ocount != '0) begin
                            r_sq_go <= 1'b1;
                            r_sq_in <= r_best;
                        end
                        r_state <= S_SQB;
                    end
                end
                S_SQB: begin
                    if (r_ocount == '0 || sq_done) begin
                        case (r_phase)
                            PH_START: begin
                                r_nwe    <= 1'b1;
                                r_nwaddr <= '0;
                                r_nwdata <= {r_q, sq_val};
                                r_ncount <= NCW'(1);
                                r_valid  <= 1'b1;
                                r_status <= ST_START;
                                r_o_node <= '0;
                                r_o_nbr  <= '0;
                                r_o_pos  <= r_q;
                                r_o_bub  <= sq_val;
                                r_last   <= 1'b1;
                                r_state  <= S_IDLE;
                            end
                            PH_OWN: begin
                                r_own   <= sq_val;
                                r_state <= S_DECIDE;
                            end
                            default: begin
                                r_nb    <= sq_val;
                                r_state <= S_LIM;
                            end
                        endcase
                    end
                end
                S_DECIDE: begin
                    if (r_d < lim) begin
                        r_q     <= r_p;
                        r_state <= S_NBGO;
                    end else if (r_d == '0) begin
                        r_q     <= r_npos;
                        r_state <= S_NBGO;
                    end else begin
                        r_k     <= 2'd0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_neg    <= (pk < nk);
                    r_prod   <= PROD_W'(axis_gap(pk, nk)) * PROD_W'(r_nbub);
                    r_div_go <= 1'b1;
                    r_state  <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    r_q[(2 - r_k) * 16 +: 16] <= qk;
                    if (r_k == 2'd2) begin
                        r_state <= S_NBGO;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_MUL;
                    end
                end
                S_NBGO: begin
                    r_tgt       <= r_q;
                    r_phase     <= PH_NEW;
                    r_mode      <= M_BUB;
                    r_src_node  <= 1'b0;
                    r_scan_on   <= (r_ocount != '0);
                    r_scan_addr <= '0;
                    r_scan_end  <= SW'(r_ocount - OCW'(1));
                    r_state     <= S_BUB;
                end
                S_LIM: begin
                    r_lim2      <= 36'(nb_inc) * 36'(nb_inc);
                    r_nwe       <= 1'b1;
                    r_nwaddr    <= r_idx;
                    r_nwdata    <= {r_q, r_nb};
                    r_pend      <= r_idx;
                    r_mode      <= M_LINK;
                    r_src_node  <= 1'b1;
                    r_scan_on   <= 1'b1;
                    r_scan_addr <= '0;
                    r_scan_end  <= SW'(r_idx - NW'(1));
                    r_state     <= S_LINK;
                end
                S_LINK: begin
                    // held-back edge goes out last once the scan drains
                    if (scan_idle) begin
                        r_valid  <= 1'b1;
                        r_status <= ST_EDGE;
                        r_o_node <= r_idx;
                        r_o_nbr  <= r_pend;
                        r_o_pos  <= r_q;
                        r_o_bub  <= r_nb;
                        r_last   <= 1'b1;
                        r_ncount <= r_ncount + NCW'(1);
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy             = (r_state != S_IDLE);
    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_node_index     = 6'(r_o_node);
    assign o_neighbor_index = 6'(r_o_nbr);
    assign o_node_x         = r_o_pos[47:32];
    assign o_node_y         = r_o_pos[31:16];
    assign o_node_z         = r_o_pos[15:0];
    assign o_bubble         = r_o_bub;
    assign o_last           = r_last;
endmodule

// ----- rtl/brni_chk.sv -----
// brni_chk: port-level checks on result beats of the node insertion block
// depends on brni_pkg; bound to bubble_roadmap_node_insert_top
module brni_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        busy,
    input logic        o_valid,
    input logic [1:0]  o_status,
    input logic [5:0]  o_node_index,
    input logic [5:0]  o_neighbor_index,
    input logic [15:0] o_node_x,
    input logic [16:0] o_bubble,
    input logic        o_last
);
    import brni_pkg::*;

    // reject beats are single and carry zeros
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_REJECT |-> o_last && o_node_index == 6'd0
            && o_node_x == 16'd0 && o_bubble == 17'd0)
        else $error("reject beat not clean");

    // obstacle beats are single and carry a zero neighbor index
    a_obst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_OBST |-> o_last && o_neighbor_index == 6'd0)
        else $error("obstacle beat not clean");

    // start placement is always node zero, one beat
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_START |-> o_last && o_node_index == 6'd0)
        else $error("start beat wrong");

    // more edges follow: the block keeps working
    a_edge_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_EDGE && !o_last |-> busy)
        else $error("edge run ended without last");
endmodule

bind bubble_roadmap_node_insert_top brni_chk u_brni_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .busy             (busy),
    .o_valid          (o_valid),
    .o_status         (o_status),
    .o_node_index     (o_node_index),
    .o_neighbor_index (o_neighbor_index),
    .o_node_x         (o_node_x),
    .o_bubble         (o_bubble),
    .o_last           (o_last)
);

// ----- test/tb.sv -----
// tb: self-checking bench for bubble_roadmap_node_insert_top
// holds its own roadmap predictor; a queue-fed driver and a clocked monitor
// depends on brni_pkg and the block's rtl
module tb;
    import brni_pkg::*;

    localparam int NODE_MAX = 64;
    localparam int OBST_MAX = 1024;
    localparam logic [1:0] OP_BAD = 2'd3;   // opcode the block never uses
    localparam int WATCHDOG = 40000;

    typedef struct {
        logic [1:0]  op;
        logic [15:0] x, y, z;
        bit          drain;   // hold this beat until all results are back
    } t_cmd;

    typedef struct {
        logic [1:0]  status;
        logic [5:0]  node, nbr;
        logic [15:0] x, y, z;
        logic [16:0] bub;
        logic        last;
    } t_edge;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_opcode = '0;
    logic [15:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [5:0]  o_node_index, o_neighbor_index;
    logic [15:0] o_node_x, o_node_y, o_node_z;
    logic [16:0] o_bubble;
    logic        o_last;

    bubble_roadmap_node_insert_top u_dut (.*);

    // 4 time unit clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------- roadmap predictor ----------------
    logic [15:0] obst_pos [OBST_MAX][3];
    int          obst_cnt;
    logic [15:0] node_pos [NODE_MAX][3];
    logic [16:0] node_bub [NODE_MAX];
    logic [63:0] links [NODE_MAX];
    int          node_cnt;

    t_edge  pending_edges[$];
    t_cmd   cmd_q[$];
    int     errors, beats_in, beats_out, rejects, edges_seen;

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned r, t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (longint'(1) << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    function automatic longint unsigned gap_sq(input logic [15:0] a [3],
                                               input logic [15:0] b [3]);
        longint unsigned s;
        longint d;
        s = 0;
        for (int k = 0; k < 3; k++) begin
            d = longint'(a[k]) - longint'(b[k]);
            s += d * d;
        end
        return s;
    endfunction

    // distance to the nearest obstacle, zero with an empty store
    function automatic logic [16:0] free_radius(input logic [15:0] p [3]);
        longint unsigned best, s;
        if (obst_cnt == 0) return '0;
        best = gap_sq(p, obst_pos[0]);
        for (int i = 1; i < obst_cnt; i++) begin
            s = gap_sq(p, obst_pos[i]);
            if (s < best) best = s;
        end
        return 17'(floor_root(best));
    endfunction

    function automatic t_edge mk(input logic [1:0] st, input int n, input int m,
                                 input logic [15:0] p [3], input logic [16:0] b,
                                 input logic l);
        t_edge e;
        e.status = st; e.node = 6'(n); e.nbr = 6'(m);
        e.x = p[0]; e.y = p[1]; e.z = p[2]; e.bub = b; e.last = l;
        return e;
    endfunction

    // append one expected result beat
    function automatic void expect_beat(input t_edge e);
        pending_edges.insert(pending_edges.size(), e);
    endfunction

    task automatic grow_roadmap(input logic [1:0] op, input logic [15:0] px,
                                input logic [15:0] py, input logic [15:0] pz);
        logic [15:0] p [3], q [3], zero [3];
        longint unsigned best, s, d, lim;
        longint diff, v;
        logic [16:0] own, nbub, nb;
        int near, idx;
        p[0] = px; p[1] = py; p[2] = pz;
        zero[0] = '0; zero[1] = '0; zero[2] = '0;
        if (op == OP_OBST && obst_cnt < OBST_MAX) begin
            obst_pos[obst_cnt] = p;
            obst_cnt++;
            expect_beat(mk(ST_OBST, 0, 0, zero, '0, 1'b1));
        end else if (op == OP_START) begin
            node_pos[0] = p;
            node_bub[0] = free_radius(p);
            foreach (links[i]) links[i] = '0;
            node_cnt = 1;
            expect_beat(mk(ST_START, 0, 0, p, node_bub[0], 1'b1));
        end else if (op == OP_SAMPLE && node_cnt >= 1 && node_cnt < NODE_MAX) begin
            // nearest node, lowest index wins a tie
            near = 0;
            best = gap_sq(p, node_pos[0]);
            for (int i = 1; i < node_cnt; i++) begin
                s = gap_sq(p, node_pos[i]);
                if (s < best) begin best = s; near = i; end
            end
            d = floor_root(best);
            own = free_radius(p);
            nbub = node_bub[near];
            lim = (nbub > own) ? nbub : own;
            if (d < lim) q = p;
            else if (d == 0) q = node_pos[near];
            else begin
                // steer onto the nearest node's bubble edge
                for (int k = 0; k < 3; k++) begin
                    diff = longint'(p[k]) - longint'(node_pos[near][k]);
                    v = longint'(node_pos[near][k]) + diff * longint'(nbub) / longint'(d);
                    if (v < 0) v = 0;
                    if (v > 65535) v = 65535;
                    q[k] = 16'(v);
                end
            end
            idx = node_cnt;
            node_pos[idx] = q;
            nb = free_radius(q);
            node_bub[idx] = nb;
            node_cnt++;
            links[idx][idx] = 1'b1;
            expect_beat(mk(ST_EDGE, idx, idx, q, nb, 1'b0));
            for (int i = 0; i < idx; i++) begin
                if (floor_root(gap_sq(q, node_pos[i])) <= nb) begin
                    links[idx][i] = 1'b1;
                    links[i][idx] = 1'b1;
                    expect_beat(mk(ST_EDGE, idx, i, q, nb, 1'b0));
                end
            end
            pending_edges[$].last = 1'b1;
        end else begin
            expect_beat(mk(ST_REJECT, 0, 0, zero, '0, 1'b1));
        end
    endtask

    // ---------------- stimulus helpers ----------------
    task automatic add(input logic [1:0] op, input logic [15:0] x, input logic [15:0] y,
                       input logic [15:0] z, input bit drain = 0);
        t_cmd c;
        c.op = op; c.x = x; c.y = y; c.z = z; c.drain = drain;
        cmd_q.insert(cmd_q.size(), c);
    endtask

    // mostly a crowded region so bubbles and edges stay interesting
    function automatic logic [15:0] coord();
        if ($urandom_range(0, 7) == 0) return 16'($urandom);
        return 16'(16'h8000 + $urandom_range(0, 16'h0fff) - 16'h0800);
    endfunction

    task automatic add_rand(input logic [1:0] op);
        add(op, coord(), coord(), coord());
    endtask

    // ---------------- driver ----------------
    bit took;          // the offered beat was taken at the last rising edge
    int burst_left, gap_left;

    always @(negedge i_clk) begin
        logic nxt;
        nxt = 1'b0;
        if (!i_rst_n) begin
            nxt = 1'b0;
        end else if (start && !took) begin
            nxt = 1'b1;                      // beat still waiting for busy to drop
        end else begin
            if (burst_left == 0 && gap_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
            if (gap_left > 0) begin
                gap_left--;
            end else if (cmd_q.size() > 0 &&
                         !(cmd_q[0].drain && pending_edges.size() != 0)) begin
                i_opcode <= cmd_q[0].op;
                i_pos_x  <= cmd_q[0].x;
                i_pos_y  <= cmd_q[0].y;
                i_pos_z  <= cmd_q[0].z;
                nxt = 1'b1;
                burst_left--;
            end
        end
        took = 1'b0;
        start <= nxt;
    end

    // ---------------- monitor and checks ----------------
    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    int idle_cycles;

    always @(posedge i_clk) begin
        t_edge e;
        if (i_rst_n) begin
            idle_cycles++;
            if (start && !busy) begin
                grow_roadmap(i_opcode, i_pos_x, i_pos_y, i_pos_z);
                void'(cmd_q.pop_front());
                took = 1'b1;
                beats_in++;
                idle_cycles = 0;
            end
            if (o_valid) begin
                idle_cycles = 0;
                beats_out++;
                if (o_status == ST_REJECT) rejects++;
                if (o_status == ST_EDGE) edges_seen++;
                if (pending_edges.size() == 0) begin
                    $display("%0t: unexpected result, status %0d", $time, o_status);
                    errors++;
                end else begin
                    e = pending_edges.pop_front();
                    check_field("status", e.status, o_status);
                    check_field("node_index", e.node, o_node_index);
                    check_field("neighbor_index", e.nbr, o_neighbor_index);
                    check_field("node_x", e.x, o_node_x);
                    check_field("node_y", e.y, o_node_y);
                    check_field("node_z", e.z, o_node_z);
                    check_field("bubble", e.bub, o_bubble);
                    check_field("last", e.last, o_last);
                end
            end
            if (idle_cycles >= WATCHDOG) begin
                $display("%0t: watchdog expired", $time);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ---------------- sequence ----------------
    initial begin
        int n;
        obst_cnt = 0; node_cnt = 0;
        foreach (links[i]) links[i] = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: rejects first, then an obstacle-free graph
        add(OP_SAMPLE, 16'h1234, 16'h0, 16'hffff);       // sample before any start
        add(OP_BAD, 16'hffff, 16'hffff, 16'hffff);       // unused opcode
        add(OP_START, 16'h0, 16'h0, 16'h0);              // bubble zero
        add(OP_SAMPLE, 16'hffff, 16'hffff, 16'hffff);    // steering with zero bubble
        add(OP_SAMPLE, 16'h0, 16'h0, 16'h0);             // zero distance, tie
        add(OP_OBST, 16'h0, 16'h0, 16'h0);
        add(OP_OBST, 16'hffff, 16'hffff, 16'hffff);
        add(OP_OBST, 16'h8000, 16'h4000, 16'h2000);
        add(OP_SAMPLE, 16'h5555, 16'haaaa, 16'h5555);    // late obstacles, old bubbles kept
        add(OP_START, 16'hffff, 16'h0, 16'h8000, 1);
        add(OP_SAMPLE, 16'hffff, 16'h0, 16'h8000);       // same spot as start
        add(OP_SAMPLE, 16'h0, 16'hffff, 16'h0);          // far, steered and clamped
        add(OP_SAMPLE, 16'hfff0, 16'h0010, 16'h8010);    // inside the bubble, kept
        add(OP_SAMPLE, 16'haaaa, 16'h5555, 16'haaaa);
        add(OP_START, 16'h8000, 16'h8000, 16'h8000);
        add(OP_SAMPLE, 16'h8100, 16'h7f00, 16'h8000);
        add(OP_SAMPLE, 16'h7f00, 16'h8100, 16'h8000);

        // random phases: a few obstacles, a start, then a run of samples
        for (int ph = 0; ph < 4; ph++) begin
            repeat ($urandom_range(1, 5)) add_rand(OP_OBST);
            add_rand(OP_START);
            n = (ph == 2) ? 66 : $urandom_range(6, 14);   // one phase fills the node store
            repeat (n) begin
                if (ph != 2 && $urandom_range(0, 19) == 0)
                    add(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                        16'($urandom));
                else add_rand(OP_SAMPLE);
            end
        end

        // wait for the graph to settle, then a final start and samples
        add(OP_OBST, 16'h1000, 16'h1000, 16'h1000, 1);
        add_rand(OP_START);
        add_rand(OP_SAMPLE);
        add_rand(OP_SAMPLE);

        wait (cmd_q.size() == 0 && !start);
        wait (pending_edges.size() == 0);
        repeat (60) @(posedge i_clk);
        $display("tb: %0d commands, %0d results (%0d edges, %0d refused), %0d obstacles",
                 beats_in, beats_out, edges_seen, rejects, obst_cnt);
        $display("tb: steering, zero bubbles, rejects and a node store run to full");
        if (errors == 0 && pending_edges.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/brni_pkg.sv
rtl/brni_sqrt.sv
rtl/brni_div.sv
rtl/bubble_roadmap_node_insert_top.sv
rtl/brni_chk.sv
test/tb.sv
